// ===== rtl/core/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// Round robin thread slot scheduler package
// Shared constants, slot state and status codes, sequencer states and the
// request word that the sequencer sends to the slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

   // Number of thread slots and the width of a slot index.
   localparam int THREAD_SLOTS = 8;
   localparam int SLOT_W       = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;

   // Fixed port widths.
   localparam int OP_W      = 2;
   localparam int TARGET_W  = 4;
   localparam int STATUS_W  = 2;
   localparam int SLOT_ID_W = 3;

   typedef logic [SLOT_W-1:0] slot_idx_type;

   localparam slot_idx_type SLOT_FIRST = slot_idx_type'(0);
   localparam slot_idx_type SLOT_ONE   = slot_idx_type'(1);
   localparam slot_idx_type SLOT_LAST  = slot_idx_type'(THREAD_SLOTS - 1);

   // Life cycle of one thread slot.
   typedef enum logic [1:0] {
      ST_UNUSED   = 2'd0,
      ST_RUNNABLE = 2'd1,
      ST_RUNNING  = 2'd2,
      ST_ZOMBIE   = 2'd3
   } slot_state_type;

   // Operation codes of a request word.
   typedef enum logic [OP_W-1:0] {
      OP_CREATE = 2'd0,
      OP_YIELD  = 2'd1,
      OP_EXIT   = 2'd2,
      OP_JOIN   = 2'd3
   } op_type;

   // Status codes of a response word.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_BAD_ID  = 2'd2,
      STATUS_PENDING = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_CREATE,
      S_EXIT,
      S_SCAN,
      S_FIX_OLD,
      S_SET_NEW,
      S_JOIN,
      S_DONE
   } seq_state_type;

   // One read and one write of the slot table per cycle.
   typedef struct packed {
      slot_idx_type   rd_addr;
      logic           wr_en;
      slot_idx_type   wr_addr;
      slot_state_type wr_data;
   } table_req_type;

   // Next slot in round robin order, wrapping after the last slot.
   function automatic slot_idx_type next_slot(input slot_idx_type s);
      slot_idx_type r;
      if (s == SLOT_LAST) begin
         r = SLOT_FIRST;
      end else begin
         r = s + SLOT_ONE;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rrts_slot_table.sv =====
// ----------------------------------------------------------------------------
// Slot state table
// Holds the state of every thread slot, with one read port and one write
// port. Reset makes slot zero running and every other slot unused.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_slot_table
   import rrts_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire table_req_type  req,
   output      slot_state_type rd_data
);

   slot_state_type slots_ff [THREAD_SLOTS];

   // Read port: the sequencer chooses one slot per cycle.
   assign rd_data = slots_ff[req.rd_addr];

   // Write port with reset to the boot state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < THREAD_SLOTS; i++) begin
            slots_ff[i] <= (i == 0) ? ST_RUNNING : ST_UNUSED;
         end
      end else if (req.wr_en) begin
         slots_ff[req.wr_addr] <= req.wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rrts_sequencer.sv =====
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Steps through the slot table one slot per cycle to carry out create,
// yield, exit and join, keeps the current slot and holds the response word.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_sequencer
   import rrts_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic [OP_W-1:0]      req_operation,
   input  wire logic [TARGET_W-1:0]  req_target_id,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [STATUS_W-1:0]  rsp_status,
   output      logic [SLOT_ID_W-1:0] rsp_slot_id,
   output      logic                 rsp_switched,
   output      table_req_type        tbl_req,
   input  wire slot_state_type       tbl_rd_data
);

   seq_state_type state_ff, state_in;
   slot_idx_type  cur_ff, cur_in;
   slot_idx_type  addr_ff, addr_in;
   slot_idx_type  cnt_ff, cnt_in;
   slot_idx_type  found_ff, found_in;
   slot_idx_type  target_ff, target_in;
   status_type    status_ff, status_in;
   slot_idx_type  id_ff, id_in;
   logic          switched_ff, switched_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   slot_idx_type  rsp_id_ff, rsp_id_in;
   logic          rsp_switched_ff, rsp_switched_in;

   logic accept;
   logic out_free;
   logic bad_id;
   op_type op;

   assign op       = op_type'(req_operation);
   assign accept   = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign bad_id   = (req_target_id == '0) || (32'(req_target_id) >= THREAD_SLOTS);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (op)
                  OP_CREATE: state_in = S_CREATE;
                  OP_YIELD:  state_in = S_SCAN;
                  OP_EXIT:   state_in = S_EXIT;
                  OP_JOIN:   state_in = bad_id ? S_DONE : S_JOIN;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_CREATE: begin
            if (tbl_rd_data == ST_UNUSED || addr_ff == SLOT_LAST) begin
               state_in = S_DONE;
            end
         end
         S_EXIT:    state_in = S_SCAN;
         S_SCAN: begin
            if (tbl_rd_data == ST_RUNNABLE) begin
               state_in = S_FIX_OLD;
            end else if (cnt_ff == SLOT_LAST) begin
               state_in = S_DONE;
            end
         end
         S_FIX_OLD: state_in = S_SET_NEW;
         S_SET_NEW: state_in = S_DONE;
         S_JOIN:    state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // Table access and working registers.
   always_comb begin
      tbl_req         = '{rd_addr: addr_ff, wr_en: 1'b0, wr_addr: addr_ff,
                          wr_data: ST_UNUSED};
      cur_in          = cur_ff;
      addr_in         = addr_ff;
      cnt_in          = cnt_ff;
      found_in        = found_ff;
      target_in       = target_ff;
      status_in       = status_ff;
      id_in           = id_ff;
      switched_in     = switched_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_switched_in = rsp_switched_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in   = STATUS_OK;
               id_in       = cur_ff;
               switched_in = 1'b0;
               cnt_in      = SLOT_FIRST;
               target_in   = slot_idx_type'(req_target_id);
               case (op)
                  OP_CREATE: addr_in = SLOT_ONE;
                  OP_YIELD:  addr_in = next_slot(cur_ff);
                  OP_JOIN: begin
                     if (bad_id) begin
                        status_in = STATUS_BAD_ID;
                     end
                  end
                  default:   addr_in = addr_ff;
               endcase
            end
         end
         // Lowest unused slot from one upward.
         S_CREATE: begin
            if (tbl_rd_data == ST_UNUSED) begin
               tbl_req.wr_en   = 1'b1;
               tbl_req.wr_data = ST_RUNNABLE;
               id_in           = addr_ff;
            end else if (addr_ff == SLOT_LAST) begin
               status_in = STATUS_FULL;
            end else begin
               addr_in = addr_ff + SLOT_ONE;
            end
         end
         // Mark the current slot zombie, then search as for a yield.
         S_EXIT: begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = cur_ff;
            tbl_req.wr_data = ST_ZOMBIE;
            addr_in         = next_slot(cur_ff);
            cnt_in          = SLOT_FIRST;
         end
         // Round robin search, ending at the current slot itself.
         S_SCAN: begin
            if (tbl_rd_data == ST_RUNNABLE) begin
               found_in = addr_ff;
            end else begin
               addr_in = next_slot(addr_ff);
               cnt_in  = cnt_ff + SLOT_ONE;
            end
         end
         // A running old slot steps back to runnable.
         S_FIX_OLD: begin
            tbl_req.rd_addr = cur_ff;
            tbl_req.wr_addr = cur_ff;
            tbl_req.wr_data = ST_RUNNABLE;
            tbl_req.wr_en   = (tbl_rd_data == ST_RUNNING);
         end
         S_SET_NEW: begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = found_ff;
            tbl_req.wr_data = ST_RUNNING;
            cur_in          = found_ff;
            id_in           = found_ff;
            switched_in     = (found_ff != cur_ff);
         end
         // Reap a zombie, or report whether the caller must retry.
         S_JOIN: begin
            tbl_req.rd_addr = target_ff;
            tbl_req.wr_addr = target_ff;
            tbl_req.wr_data = ST_UNUSED;
            tbl_req.wr_en   = (tbl_rd_data == ST_ZOMBIE);
            if (tbl_rd_data == ST_RUNNABLE || tbl_rd_data == ST_RUNNING) begin
               status_in = STATUS_PENDING;
            end
         end
         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_id_in       = id_ff;
               rsp_switched_in = switched_ff;
            end
         end
         default: begin
            tbl_req.wr_en = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= SLOT_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and response registers.
   always_ff @(posedge clock) begin
      addr_ff         <= addr_in;
      cnt_ff          <= cnt_in;
      found_ff        <= found_in;
      target_ff       <= target_in;
      status_ff       <= status_in;
      id_ff           <= id_in;
      switched_ff     <= switched_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_id_ff       <= rsp_id_in;
      rsp_switched_ff <= rsp_switched_in;
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot_id  = SLOT_ID_W'(rsp_id_ff);
   assign rsp_switched = rsp_switched_ff;

endmodule

`default_nettype wire

// ===== rtl/core/round_robin_thread_slot_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Round robin thread slot scheduler
// Thread slot table with create, yield, exit and join, one response word per
// request word.
// ----------------------------------------------------------------------------
// The block takes one request word at a time and returns one response word.
// A sequencer walks the slot table through its single read port, one slot
// per cycle: create scans for an unused slot, yield scans for a runnable
// slot, exit marks the current slot zombie before the yield scan, and join
// checks its target slot directly (a bad id goes straight to the response).
// A request is taken only in the idle state. Requests stall until the
// response is in the output register; a finished response may wait there
// while the next request is already being worked on. After reset slot zero
// is running and the current slot, and every other slot is unused.
`default_nettype none

module round_robin_thread_slot_scheduler_top
   import rrts_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic [OP_W-1:0]      req_operation,
   input  wire logic [TARGET_W-1:0]  req_target_id,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [STATUS_W-1:0]  rsp_status,
   output      logic [SLOT_ID_W-1:0] rsp_slot_id,
   output      logic                 rsp_switched
);

   table_req_type  tbl_req;
   slot_state_type tbl_rd_data;

   // Slot state storage.
   rrts_slot_table u_table (
      .clock   (clock),
      .reset   (reset),
      .req     (tbl_req),
      .rd_data (tbl_rd_data)
   );

   // Operation sequencer and response register.
   rrts_sequencer u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_target_id (req_target_id),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_slot_id   (rsp_slot_id),
      .rsp_switched  (rsp_switched),
      .tbl_req       (tbl_req),
      .tbl_rd_data   (tbl_rd_data)
   );

endmodule

`default_nettype wire
